// File: rtl/gtpu_header_parser_unit_macros.svh
// assertion macros for the gtp-u header parser
// used by the top level, which includes this file inside its module body
`ifndef GTPU_HEADER_PARSER_UNIT_MACROS_SVH
`define GTPU_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GTPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gtpu assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GTPU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gtpu assertion failed");

`endif

// File: rtl/gtpu_pkg.sv
// shared types and constants for the gtp-u header parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gtpu_pkg;

	// default width of the byte counter and header end pointer
	localparam int COUNT_BITS_DEF = 17;

	// fixed field widths
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int DLEN_W   = 16;
	localparam int TEID_W   = 32;
	localparam int HLEN_W   = 17;

	// header layout
	localparam int HDR_BASE_LEN = 8;
	localparam int HDR_OPT_LEN  = 12;
	localparam int LAST_FIXED   = 7;

	// flags byte masks
	localparam logic [7:0] VER_PT_MASK = 8'hf0;
	localparam logic [7:0] VER_PT_GTPU = 8'h30;
	localparam logic [7:0] FLAG_E      = 8'h04;
	localparam logic [7:0] FLAG_S      = 8'h02;
	localparam logic [7:0] FLAG_PN     = 8'h01;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_SHORT     = 3'd1;
	localparam status_t ST_BAD_VER   = 3'd2;
	localparam status_t ST_LEN_MISM  = 3'd3;
	localparam status_t ST_OVERRUN   = 3'd4;
	localparam status_t ST_ZERO_EXT  = 3'd5;

endpackage

`default_nettype wire

// File: rtl/gtpu_header_parser_unit.sv
// gtp-u header parser top level: byte stream in, one result per packet out
// depends on gtpu_pkg and gtpu_header_parser_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// usage
// s_axis carries one packet byte per transaction in tdata, tlast on the final
// byte. m_axis carries one result per packet: tuser holds the status, tdata
// the captured header fields and the total header length (0 on error).
// an accepted byte is held in an input register; from there the parser state
// is updated and, for a final byte, the result register is loaded, which
// drives the result on m_axis.
// while s_axis_tready is high one byte is taken every cycle; the rate is set by
// the single pass through the extension length add and the header end compare
// in the parse stage. while a result waits on m_axis, further bytes of the next
// packet are still taken; only a second final byte waits in the input register,
// and then s_axis_tready falls until the pending result is taken.
// arst_n clears the input and result valid flags and returns the parser to
// the start of a packet; after a final byte the parser returns there too.
// byte and header end counters saturate at 2^COUNT_BITS - 1.

module gtpu_header_parser_unit #(
	parameter int COUNT_BITS = gtpu_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tlast,   // last_byte
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,   // [7:0] flags_byte, [15:8] message_type,
	                                         // [31:16] declared_length, [63:32] tunnel_id,
	                                         // [80:64] header_length, [87:81] zero
	output gtpu_pkg::status_t m_axis_tuser   // [2:0] status
);

	import gtpu_pkg::*;

	`include "gtpu_header_parser_unit_macros.svh"

	localparam int CW = COUNT_BITS;
	localparam int LW = COUNT_BITS + 1;
	localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              advance;

	// parser state
	logic [CW-1:0]     byte_idx_q;
	logic [63:0]       hdr_words_q;
	logic [CW-1:0]     hdr_end_q;
	logic              chain_open_q;
	logic [BYTE_W-1:0] next_type_q;
	logic              zero_ext_q;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [7:0]        flags_q;
	logic [7:0]        msg_type_q;
	logic [DLEN_W-1:0] dlen_q;
	logic [TEID_W-1:0] teid_q;
	logic [HLEN_W-1:0] hlen_q;

	// next-state values of the parse stage
	logic [63:0]       hdr_words_n;
	logic [CW-1:0]     hdr_end_n;
	logic              chain_open_n;
	logic [BYTE_W-1:0] next_type_n;
	logic              zero_ext_n;
	logic [LW-1:0]     idx_plus1;
	logic [LW-1:0]     ext_end;
	status_t           status_n;
	logic [7:0]        fl_n;
	logic [7:0]        mt_n;
	logic [DLEN_W-1:0] dl_n;
	logic [TEID_W-1:0] te_n;

	// handshake: parse stage moves unless a final byte meets an untaken full result
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parse step for the byte in the input register
	always_comb begin
		idx_plus1    = {1'b0, byte_idx_q} + LW'(1);
		ext_end      = {1'b0, hdr_end_q} + LW'({byte_s1, 2'b00});
		hdr_words_n  = hdr_words_q;
		hdr_end_n    = hdr_end_q;
		chain_open_n = chain_open_q;
		next_type_n  = next_type_q;
		zero_ext_n   = zero_ext_q;
		if (byte_idx_q < CW'(HDR_BASE_LEN)) begin
			hdr_words_n = {hdr_words_q[55:0], byte_s1};
		end
		if (byte_idx_q == CW'(LAST_FIXED)) begin
			hdr_end_n    = ((hdr_words_n[63:56] & (FLAG_E | FLAG_S | FLAG_PN)) != 8'h00)
				? CW'(HDR_OPT_LEN) : CW'(HDR_BASE_LEN);
			chain_open_n = (hdr_words_n[63:56] & FLAG_E) != 8'h00;
			next_type_n  = '0;
		end else if (byte_idx_q >= CW'(HDR_BASE_LEN) && byte_idx_q < COUNT_MAX
				&& chain_open_q) begin
			if (next_type_q == '0) begin
				// next-type byte closes the previous part
				if (idx_plus1 == {1'b0, hdr_end_q}) begin
					if (byte_s1 == '0) begin
						chain_open_n = 1'b0;
					end else begin
						next_type_n = byte_s1;
					end
				end
			end else if (byte_idx_q == hdr_end_q) begin
				// extension length byte in 4-byte units
				if (byte_s1 == '0) begin
					zero_ext_n   = 1'b1;
					chain_open_n = 1'b0;
				end else begin
					hdr_end_n   = (ext_end > {1'b0, COUNT_MAX}) ? COUNT_MAX : ext_end[CW-1:0];
					next_type_n = '0;
				end
			end
		end
	end

	// result fields and status priority
	always_comb begin
		fl_n = hdr_words_n[63:56];
		mt_n = hdr_words_n[55:48];
		dl_n = hdr_words_n[47:32];
		te_n = hdr_words_n[31:0];
		priority if (idx_plus1 < LW'(HDR_BASE_LEN)) begin
			status_n = ST_SHORT;
		end else if ((fl_n & VER_PT_MASK) != VER_PT_GTPU) begin
			status_n = ST_BAD_VER;
		end else if ((LW'(dl_n) + LW'(HDR_BASE_LEN)) != idx_plus1) begin
			status_n = ST_LEN_MISM;
		end else if (zero_ext_n) begin
			status_n = ST_ZERO_EXT;
		end else if ({1'b0, hdr_end_n} >= idx_plus1) begin
			status_n = ST_OVERRUN;
		end else begin
			status_n = ST_OK;
		end
	end

	// parser state, back to packet start after a final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q   <= '0;
			hdr_words_q  <= '0;
			hdr_end_q    <= CW'(HDR_BASE_LEN);
			chain_open_q <= 1'b0;
			next_type_q  <= '0;
			zero_ext_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				byte_idx_q   <= '0;
				hdr_words_q  <= '0;
				hdr_end_q    <= CW'(HDR_BASE_LEN);
				chain_open_q <= 1'b0;
				next_type_q  <= '0;
				zero_ext_q   <= 1'b0;
			end else begin
				if (byte_idx_q < COUNT_MAX) begin
					byte_idx_q <= byte_idx_q + CW'(1);
				end
				hdr_words_q  <= hdr_words_n;
				hdr_end_q    <= hdr_end_n;
				chain_open_q <= chain_open_n;
				next_type_q  <= next_type_n;
				zero_ext_q   <= zero_ext_n;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_n;
			if (status_n == ST_SHORT) begin
				flags_q    <= '0;
				msg_type_q <= '0;
				dlen_q     <= '0;
				teid_q     <= '0;
			end else begin
				flags_q    <= fl_n;
				msg_type_q <= mt_n;
				dlen_q     <= dl_n;
				teid_q     <= te_n;
			end
			hlen_q <= (status_n == ST_OK) ? hdr_end_n[HLEN_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {7'd0, hlen_q, teid_q, dlen_q, msg_type_q, flags_q};

	// checks
	`GTPU_ASSERT_IMP(a_ok_len, clk, arst_n, m_axis_tvalid && m_axis_tuser == ST_OK,
		hlen_q >= HLEN_W'(HDR_BASE_LEN) && hlen_q < HLEN_W'(dlen_q) + HLEN_W'(HDR_BASE_LEN))
	`GTPU_ASSERT_IMP(a_err_len, clk, arst_n, m_axis_tvalid && m_axis_tuser != ST_OK,
		hlen_q == '0)
	`GTPU_ASSERT_NXT(a_stall, clk, arst_n,
		valid_s1 && last_s1 && out_valid_q && !m_axis_tready, valid_s1 && last_s1 && out_valid_q)

endmodule

`default_nettype wire

// File: dv/gtpu_header_parser_unit_test.sv
`timescale 1ns / 1ps
// testbench for gtpu_header_parser_unit: feeds gtp-u packets byte by byte and checks
// every result against a behavioral parser kept in a small scoreboard class
// depends on gtpu_pkg and the gtpu_header_parser_unit top level

module gtpu_header_parser_unit_test;
	import gtpu_pkg::*;

	localparam int unsigned CNT_MAX = (1 << COUNT_BITS_DEF) - 1;
	localparam int TOTAL_BYTES  = 700;
	localparam int LONG_HOLD    = 400;

	typedef enum int {
		PK_GOOD, PK_BAD_VER, PK_BAD_LEN, PK_ZERO_EXT, PK_OPEN_CHAIN, PK_SHORT, PK_NOISE
	} pkt_kind_t;

	// how the extension chain of a generated packet ends
	typedef enum int {CH_CLOSED, CH_ZERO_LEN, CH_OPEN} chain_end_t;

	typedef struct {
		status_t     status;
		logic [7:0]  flags;
		logic [7:0]  msg_type;
		logic [15:0] decl_len;
		logic [31:0] teid;
		logic [16:0] hdr_len;
	} parse_result_t;

	// behavioral parser plus the queue of results still owed by the block
	class header_scoreboard_t;
		int unsigned   byte_idx;
		int unsigned   hdr_end;
		logic [63:0]   hdr_shift;
		bit            chain_open;
		logic [7:0]    pend_type;
		bit            zero_ext;
		parse_result_t pending_results[$];
		int            errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			byte_idx = 0;
			hdr_shift = '0;
			hdr_end = HDR_BASE_LEN;
			chain_open = 1'b0;
			pend_type = '0;
			zero_ext = 1'b0;
		endfunction

		// update the parse state with one accepted byte transaction
		function void note_byte(logic [7:0] d, logic l);
			int unsigned   i;
			int unsigned   len;
			int unsigned   e;
			int unsigned   dl;
			logic [7:0]    fl;
			parse_result_t r;
			i = byte_idx;
			if (i < HDR_BASE_LEN)
				hdr_shift = {hdr_shift[55:0], d};
			if (i == LAST_FIXED) begin
				fl = hdr_shift[63:56];
				hdr_end = ((fl & (FLAG_E | FLAG_S | FLAG_PN)) != 0) ? HDR_OPT_LEN : HDR_BASE_LEN;
				chain_open = (fl & FLAG_E) != 0;
				pend_type = '0;
			end else if (i >= HDR_BASE_LEN && i < CNT_MAX && chain_open) begin
				// next-type byte closes a part, length byte opens the next extension
				if (pend_type == 0) begin
					if (i + 1 == hdr_end) begin
						if (d == 0)
							chain_open = 1'b0;
						else
							pend_type = d;
					end
				end else if (i == hdr_end) begin
					if (d == 0) begin
						zero_ext = 1'b1;
						chain_open = 1'b0;
					end else begin
						e = hdr_end + 4 * d;
						hdr_end = (e > CNT_MAX) ? CNT_MAX : e;
						pend_type = '0;
					end
				end
			end
			if (byte_idx < CNT_MAX)
				byte_idx++;
			if (!l)
				return;

			// final byte: work out the result
			len = i + 1;
			dl = hdr_shift[47:32];
			r.flags = hdr_shift[63:56];
			r.msg_type = hdr_shift[55:48];
			r.decl_len = hdr_shift[47:32];
			r.teid = hdr_shift[31:0];
			if (len < HDR_BASE_LEN)
				r.status = ST_SHORT;
			else if ((r.flags & VER_PT_MASK) != VER_PT_GTPU)
				r.status = ST_BAD_VER;
			else if (dl + HDR_BASE_LEN != len)
				r.status = ST_LEN_MISM;
			else if (zero_ext)
				r.status = ST_ZERO_EXT;
			else if (hdr_end >= len)
				r.status = ST_OVERRUN;
			else
				r.status = ST_OK;
			if (r.status == ST_SHORT) begin
				r.flags = '0;
				r.msg_type = '0;
				r.decl_len = '0;
				r.teid = '0;
			end
			r.hdr_len = (r.status == ST_OK) ? hdr_end[16:0] : '0;
			pending_results.push_back(r);
			restart();
		endfunction

		function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// compare one accepted result transaction with the oldest owed result
		function void check_result(logic [87:0] td, status_t tu);
			parse_result_t exp_r;
			if (pending_results.size() == 0) begin
				$error("result with no packet outstanding: status %0d", tu);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			check_field("status", exp_r.status, tu);
			check_field("flags_byte", exp_r.flags, td[7:0]);
			check_field("message_type", exp_r.msg_type, td[15:8]);
			check_field("declared_length", exp_r.decl_len, td[31:16]);
			check_field("tunnel_id", exp_r.teid, td[63:32]);
			check_field("header_length", exp_r.hdr_len, td[80:64]);
			check_field("tdata_pad", '0, td[87:81]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;
	status_t     m_axis_tuser;

	header_scoreboard_t sb;
	logic [7:0] pkt_bytes[$];
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	int hold_req = 0;
	int bytes_sent;

	gtpu_header_parser_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] nonzero_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	// mostly no gap, some short gaps, a few long ones
	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one byte transaction on s_axis, valid stays high when no gap follows
	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		gap = pick_gap(src_idle);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(d, l);
	endtask

	task automatic send_packet();
		for (int k = 0; k < pkt_bytes.size(); k++)
			send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1);
		bytes_sent += pkt_bytes.size();
		if ($urandom_range(0, 7) == 0)
			src_idle = !src_idle;
	endtask

	task automatic push_fixed(input logic [7:0] flags, input logic [7:0] msg,
			input logic [15:0] dl, input logic [31:0] teid);
		pkt_bytes.push_back(flags);
		pkt_bytes.push_back(msg);
		pkt_bytes.push_back(dl[15:8]);
		pkt_bytes.push_back(dl[7:0]);
		pkt_bytes.push_back(teid[31:24]);
		pkt_bytes.push_back(teid[23:16]);
		pkt_bytes.push_back(teid[15:8]);
		pkt_bytes.push_back(teid[7:0]);
	endtask

	// gtp-u packet with optional bytes, n_ext extensions and a payload
	task automatic build_gtpu(input logic [7:0] flags, input int n_ext,
			input chain_end_t chain_end, input int payload, input bit wrong_len);
		int units;
		logic [15:0] dl;
		pkt_bytes.delete();
		push_fixed(flags, rand_byte(), 16'h0, $urandom());
		if ((flags & (FLAG_E | FLAG_S | FLAG_PN)) != 0) begin
			repeat (3) pkt_bytes.push_back(rand_byte());
			if ((flags & FLAG_E) == 0)
				pkt_bytes.push_back(rand_byte());
			else
				pkt_bytes.push_back(n_ext > 0 ? nonzero_byte() : 8'h00);
		end
		for (int k = 0; k < n_ext; k++) begin
			if (chain_end == CH_ZERO_LEN && k == n_ext - 1) begin
				pkt_bytes.push_back(8'h00);
				break;
			end
			units = ($urandom_range(0, 39) == 0) ? $urandom_range(4, 255) : $urandom_range(1, 3);
			pkt_bytes.push_back(units[7:0]);
			repeat (4 * units - 2) pkt_bytes.push_back(rand_byte());
			pkt_bytes.push_back((k < n_ext - 1 || chain_end == CH_OPEN) ? nonzero_byte() : 8'h00);
		end
		repeat (payload) pkt_bytes.push_back(rand_byte());
		dl = 16'(pkt_bytes.size() - HDR_BASE_LEN);
		if (wrong_len)
			dl += 16'($urandom_range(1, 65535));
		pkt_bytes[2] = dl[15:8];
		pkt_bytes[3] = dl[7:0];
	endtask

	task automatic set_ids(input logic [7:0] msg, input logic [31:0] teid);
		pkt_bytes[1] = msg;
		pkt_bytes[4] = teid[31:24];
		pkt_bytes[5] = teid[23:16];
		pkt_bytes[6] = teid[15:8];
		pkt_bytes[7] = teid[7:0];
	endtask

	task automatic build_raw(input int n, input logic [7:0] fill, input bit rnd);
		pkt_bytes.delete();
		repeat (n) pkt_bytes.push_back(rnd ? rand_byte() : fill);
	endtask

	task automatic build_random();
		pkt_kind_t kind;
		int r;
		logic [3:0] lo;
		logic [3:0] ver;
		r = $urandom_range(0, 99);
		lo = 4'($urandom_range(0, 15));
		if (r < 55)      kind = PK_GOOD;
		else if (r < 63) kind = PK_BAD_VER;
		else if (r < 71) kind = PK_BAD_LEN;
		else if (r < 78) kind = PK_ZERO_EXT;
		else if (r < 84) kind = PK_OPEN_CHAIN;
		else if (r < 90) kind = PK_SHORT;
		else             kind = PK_NOISE;
		case (kind)
			PK_GOOD, PK_BAD_VER, PK_BAD_LEN: begin
				build_gtpu({4'h3, lo}, lo[2] ? $urandom_range(0, 3) : 0, CH_CLOSED,
					($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12), kind == PK_BAD_LEN);
				if (kind == PK_BAD_VER) begin
					ver = 4'($urandom_range(0, 14));
					if (ver >= 4'h3)
						ver++;
					pkt_bytes[0] = {ver, pkt_bytes[0][3:0]};
				end
			end
			PK_ZERO_EXT:
				build_gtpu({4'h3, lo | 4'h4}, $urandom_range(1, 3), CH_ZERO_LEN,
					$urandom_range(1, 8), 1'b0);
			PK_OPEN_CHAIN:
				build_gtpu({4'h3, lo | 4'h4}, $urandom_range(1, 3), CH_OPEN,
					$urandom_range(0, 6), 1'b0);
			PK_SHORT:
				build_raw($urandom_range(1, 7), 8'h00, 1'b1);
			default:
				build_raw($urandom_range(8, 30), 8'h00, 1'b1);
		endcase
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int n;
		int hold_seen;
		m_axis_tready = 1'b0;
		hold_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				n = LONG_HOLD;
			end else
				n = pick_gap(snk_idle);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			if ($urandom_range(0, 149) == 0)
				snk_idle = !snk_idle;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// stimulus
	initial begin
		sb = new();
		bytes_sent = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short packets
		build_raw(1, 8'h00, 1'b0);
		send_packet();
		build_raw(7, 8'hff, 1'b0);
		send_packet();
		// bare 8-byte header ends at the last byte
		build_gtpu(8'h30, 0, CH_CLOSED, 0, 1'b0);
		set_ids(8'hff, 32'hffffffff);
		send_packet();
		build_gtpu(8'h30, 0, CH_CLOSED, 1, 1'b0);
		set_ids(8'h00, 32'h00000000);
		send_packet();
		// version nibble wrong
		build_gtpu(8'h20, 0, CH_CLOSED, 4, 1'b0);
		send_packet();
		build_gtpu(8'hff, 3, CH_CLOSED, 4, 1'b0);
		send_packet();
		// length field wrong
		build_gtpu(8'h30, 0, CH_CLOSED, 3, 1'b0);
		pkt_bytes[2] = 8'hff;
		pkt_bytes[3] = 8'hff;
		send_packet();
		// optional bytes from each flag
		build_gtpu(8'h32, 0, CH_CLOSED, 2, 1'b0);
		send_packet();
		build_gtpu(8'h31, 0, CH_CLOSED, 2, 1'b0);
		send_packet();
		build_gtpu(8'h34, 0, CH_CLOSED, 2, 1'b0);
		send_packet();
		// extension chains
		build_gtpu(8'h34, 1, CH_CLOSED, 3, 1'b0);
		send_packet();
		build_gtpu(8'h37, 3, CH_CLOSED, 5, 1'b0);
		send_packet();
		build_gtpu(8'h34, 2, CH_ZERO_LEN, 4, 1'b0);
		send_packet();
		build_gtpu(8'h3c, 1, CH_ZERO_LEN, 4, 1'b0);
		send_packet();
		build_gtpu(8'h34, 2, CH_OPEN, 1, 1'b0);
		send_packet();

		// random packets, long result hold-off at their start
		hold_req++;
		while (bytes_sent < TOTAL_BYTES) begin
			build_random();
			send_packet();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("[gtpu_header_parser_unit] OK");
		else
			$display("[gtpu_header_parser_unit] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("[gtpu_header_parser_unit] ERROR");
		$finish;
	end

endmodule
